// File: rtl/hrrn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrrn_pkg
// shared widths, codes and the ready slot record of the hrrn scheduler
// ----------------------------------------------------------------------------
package hrrn_pkg;

   localparam int PID_W     = 16;
   localparam int EST_W     = 20;
   localparam int WAIT_W    = 24;
   localparam int ALPHA_W   = 9;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 5;
   localparam int CSR_IDX_W = 8;
   localparam int MUL_A_W   = WAIT_W + 1;
   localparam int MUL_B_W   = EST_W;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;

   localparam logic [1:0] REQ_ADD      = 2'd0;
   localparam logic [1:0] REQ_TICK     = 2'd1;
   localparam logic [1:0] REQ_DISPATCH = 2'd2;
   localparam logic [1:0] REQ_RETURN   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TICK_DONE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RETURNED   = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE_HRRN = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_Q8  = 8'd1;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;

   typedef struct packed {
      logic [PID_W-1:0]  proc_id;
      logic [EST_W-1:0]  estimate;
      logic [WAIT_W-1:0] wait_ms;
   } slot_type;

endpackage

// File: rtl/hrrn_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrrn_ready_queue_scheduler
// ready table scheduler with fifo or highest response ratio dispatch
// ----------------------------------------------------------------------------
// add, full, empty, plain return: result strobe in the cycle after start; tick
// reads and rewrites each entry in turn; fifo dispatch reads slot 0, hrrn dispatch
// compares cross products of each entry, then both shift the later entries down;
// hrrn return weights run time and old estimate; one request at a time, set by the
// slot memory and one multiplier; synchronous reset empties the table and clears the
// running process; slot memory is not cleared; results are strobed and cannot be stalled
module hrrn_ready_queue_scheduler #(
   parameter int READY_SLOTS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [hrrn_pkg::PID_W-1:0]        req_proc_id,
   input  logic [hrrn_pkg::EST_W-1:0]        req_burst_estimate,
   input  logic [hrrn_pkg::EST_W-1:0]        req_run_time,
   output logic                              rsp_valid,
   output logic [hrrn_pkg::STATUS_W-1:0]     rsp_status,
   output logic [hrrn_pkg::PID_W-1:0]        rsp_out_proc_id,
   output logic [hrrn_pkg::EST_W-1:0]        rsp_out_estimate,
   output logic [hrrn_pkg::COUNT_W-1:0]      rsp_ready_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hrrn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hrrn_pkg::ALPHA_W-1:0]      csr_wdata
);

   localparam int IDX_W = (READY_SLOTS > 1) ? $clog2(READY_SLOTS) : 1;
   localparam int CNT_W = $clog2(READY_SLOTS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(READY_SLOTS);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_TICK_RD  = 4'd1;
   localparam logic [3:0] S_TICK_WR  = 4'd2;
   localparam logic [3:0] S_DSP_RD0  = 4'd3;
   localparam logic [3:0] S_DSP_LD0  = 4'd4;
   localparam logic [3:0] S_SCAN_RD  = 4'd5;
   localparam logic [3:0] S_SCAN_M1  = 4'd6;
   localparam logic [3:0] S_SCAN_M2  = 4'd7;
   localparam logic [3:0] S_SCAN_CMP = 4'd8;
   localparam logic [3:0] S_REM_RD   = 4'd9;
   localparam logic [3:0] S_REM_WR   = 4'd10;
   localparam logic [3:0] S_RET_M1   = 4'd11;
   localparam logic [3:0] S_RET_M2   = 4'd12;
   localparam logic [3:0] S_RET_FIN  = 4'd13;

   function automatic logic [hrrn_pkg::EST_W-1:0] est_clamp(
      input logic [hrrn_pkg::EST_W-1:0] e
   );
      return (e == '0) ? hrrn_pkg::EST_W'(1) : e;
   endfunction

   hrrn_pkg::slot_type slot_mem [READY_SLOTS];
   hrrn_pkg::slot_type rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   hrrn_pkg::slot_type wr_data;

   logic [3:0]                     state_ff, state_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [CNT_W-1:0]               idx_ff, idx_in;
   logic [CNT_W-1:0]               idx_dec;
   logic [IDX_W-1:0]               best_idx_ff, best_idx_in;
   hrrn_pkg::slot_type             best_ff, best_in;
   hrrn_pkg::slot_type             cand_ff, cand_in;
   logic [hrrn_pkg::PROD_W-1:0]    lhs_ff, lhs_in;
   logic [hrrn_pkg::PROD_W-1:0]    acc_ff, acc_in;
   logic [hrrn_pkg::PROD_W-1:0]    ret_sum;
   logic [hrrn_pkg::EST_W-1:0]     run_ff, run_in;
   logic                           mode_ff, mode_in;
   logic [hrrn_pkg::ALPHA_W-1:0]   alpha_ff, alpha_in;
   logic [hrrn_pkg::ALPHA_W-1:0]   alpha_sat;
   logic                           running_valid_ff, running_valid_in;
   logic [hrrn_pkg::PID_W-1:0]     running_proc_ff, running_proc_in;
   logic [hrrn_pkg::EST_W-1:0]     running_est_ff, running_est_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [hrrn_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [hrrn_pkg::PID_W-1:0]     rsp_proc_ff, rsp_proc_in;
   logic [hrrn_pkg::EST_W-1:0]     rsp_est_ff, rsp_est_in;
   logic [hrrn_pkg::MUL_A_W-1:0]   mul_a;
   logic [hrrn_pkg::MUL_B_W-1:0]   mul_b;
   logic [hrrn_pkg::PROD_W-1:0]    mul_p;

   hrrn_mul_unit u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_proc_id  = rsp_proc_ff;
   assign rsp_out_estimate = rsp_est_ff;
   assign rsp_ready_count  = hrrn_pkg::COUNT_W'(count_ff);

   assign alpha_sat = (alpha_ff > hrrn_pkg::ALPHA_ONE) ? hrrn_pkg::ALPHA_ONE : alpha_ff;
   assign idx_dec   = idx_ff - CNT_ONE;
   assign ret_sum   = acc_ff + mul_p;

   // slot memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      idx_in           = idx_ff;
      best_idx_in      = best_idx_ff;
      best_in          = best_ff;
      cand_in          = cand_ff;
      lhs_in           = lhs_ff;
      acc_in           = acc_ff;
      run_in           = run_ff;
      mode_in          = mode_ff;
      alpha_in         = alpha_ff;
      running_valid_in = running_valid_ff;
      running_proc_in  = running_proc_ff;
      running_est_in   = running_est_ff;
      rsp_valid_in     = 1'b0;
      rsp_status_in    = rsp_status_ff;
      rsp_proc_in      = rsp_proc_ff;
      rsp_est_in       = rsp_est_ff;
      rd_addr          = '0;
      wr_en            = 1'b0;
      wr_addr          = count_ff[IDX_W-1:0];
      wr_data          = rd_data_ff;
      mul_a            = '0;
      mul_b            = '0;

      if (csr_valid) begin
         case (csr_index)
            hrrn_pkg::CSR_MODE_HRRN: mode_in  = csr_wdata[0];
            hrrn_pkg::CSR_ALPHA_Q8:  alpha_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               idx_in = '0;
               case (req_type)
                  hrrn_pkg::REQ_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_proc_in  = '0;
                     rsp_est_in   = '0;
                     if (count_ff == CNT_FULL) begin
                        rsp_status_in = hrrn_pkg::ST_FULL;
                     end else begin
                        wr_en            = 1'b1;
                        wr_data.proc_id  = req_proc_id;
                        wr_data.estimate = req_burst_estimate;
                        wr_data.wait_ms  = '0;
                        count_in         = count_ff + CNT_ONE;
                        rsp_status_in    = hrrn_pkg::ST_ADDED;
                     end
                  end
                  hrrn_pkg::REQ_TICK: begin
                     state_in = S_TICK_RD;
                  end
                  hrrn_pkg::REQ_DISPATCH: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = hrrn_pkg::ST_EMPTY;
                        rsp_proc_in   = '0;
                        rsp_est_in    = '0;
                     end else begin
                        state_in = S_DSP_RD0;
                     end
                  end
                  default: begin
                     if (running_valid_ff && mode_ff) begin
                        run_in   = req_run_time;
                        state_in = S_RET_M1;
                     end else begin
                        rsp_valid_in     = 1'b1;
                        rsp_status_in    = hrrn_pkg::ST_RETURNED;
                        rsp_proc_in      = running_proc_ff;
                        rsp_est_in       = running_est_ff;
                        running_valid_in = 1'b0;
                        running_proc_in  = '0;
                        running_est_in   = '0;
                     end
                  end
               endcase
            end
         end
         S_TICK_RD: begin
            if (idx_ff == count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = hrrn_pkg::ST_TICK_DONE;
               rsp_proc_in   = '0;
               rsp_est_in    = '0;
               state_in      = S_IDLE;
            end else begin
               rd_addr  = idx_ff[IDX_W-1:0];
               state_in = S_TICK_WR;
            end
         end
         S_TICK_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IDX_W-1:0];
            if (rd_data_ff.wait_ms != '1) begin
               wr_data.wait_ms = rd_data_ff.wait_ms + hrrn_pkg::WAIT_W'(1);
            end
            idx_in   = idx_ff + CNT_ONE;
            state_in = S_TICK_RD;
         end
         S_DSP_RD0: begin
            rd_addr  = '0;
            state_in = S_DSP_LD0;
         end
         S_DSP_LD0: begin
            best_in     = rd_data_ff;
            best_idx_in = '0;
            idx_in      = CNT_ONE;
            state_in    = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if ((idx_ff == count_ff) || !mode_ff) begin
               idx_in   = CNT_W'(best_idx_ff) + CNT_ONE;
               state_in = S_REM_RD;
            end else begin
               rd_addr  = idx_ff[IDX_W-1:0];
               state_in = S_SCAN_M1;
            end
         end
         S_SCAN_M1: begin
            // candidate (est + wait) * best est
            cand_in  = rd_data_ff;
            mul_a    = hrrn_pkg::MUL_A_W'(est_clamp(rd_data_ff.estimate))
                     + hrrn_pkg::MUL_A_W'(rd_data_ff.wait_ms);
            mul_b    = est_clamp(best_ff.estimate);
            state_in = S_SCAN_M2;
         end
         S_SCAN_M2: begin
            lhs_in   = mul_p;
            mul_a    = hrrn_pkg::MUL_A_W'(est_clamp(best_ff.estimate))
                     + hrrn_pkg::MUL_A_W'(best_ff.wait_ms);
            mul_b    = est_clamp(cand_ff.estimate);
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (lhs_ff > mul_p) begin
               best_in     = cand_ff;
               best_idx_in = idx_ff[IDX_W-1:0];
            end
            idx_in   = idx_ff + CNT_ONE;
            state_in = S_SCAN_RD;
         end
         S_REM_RD: begin
            if (idx_ff == count_ff) begin
               count_in         = count_ff - CNT_ONE;
               running_valid_in = 1'b1;
               running_proc_in  = best_ff.proc_id;
               running_est_in   = best_ff.estimate;
               rsp_valid_in     = 1'b1;
               rsp_status_in    = hrrn_pkg::ST_DISPATCHED;
               rsp_proc_in      = best_ff.proc_id;
               rsp_est_in       = best_ff.estimate;
               state_in         = S_IDLE;
            end else begin
               rd_addr  = idx_ff[IDX_W-1:0];
               state_in = S_REM_WR;
            end
         end
         S_REM_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_dec[IDX_W-1:0];
            wr_data  = rd_data_ff;
            idx_in   = idx_ff + CNT_ONE;
            state_in = S_REM_RD;
         end
         S_RET_M1: begin
            mul_a    = hrrn_pkg::MUL_A_W'(alpha_sat);
            mul_b    = run_ff;
            state_in = S_RET_M2;
         end
         S_RET_M2: begin
            acc_in   = mul_p;
            mul_a    = hrrn_pkg::MUL_A_W'(hrrn_pkg::ALPHA_ONE - alpha_sat);
            mul_b    = running_est_ff;
            state_in = S_RET_FIN;
         end
         S_RET_FIN: begin
            rsp_valid_in     = 1'b1;
            rsp_status_in    = hrrn_pkg::ST_RETURNED;
            rsp_proc_in      = running_proc_ff;
            rsp_est_in       = ret_sum[hrrn_pkg::EST_W+7:8];
            running_valid_in = 1'b0;
            running_proc_in  = '0;
            running_est_in   = '0;
            state_in         = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         count_ff         <= '0;
         mode_ff          <= 1'b0;
         alpha_ff         <= hrrn_pkg::ALPHA_RESET;
         running_valid_ff <= 1'b0;
         running_proc_ff  <= '0;
         running_est_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         mode_ff          <= mode_in;
         alpha_ff         <= alpha_in;
         running_valid_ff <= running_valid_in;
         running_proc_ff  <= running_proc_in;
         running_est_ff   <= running_est_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      cand_ff       <= cand_in;
      lhs_ff        <= lhs_in;
      acc_ff        <= acc_in;
      run_ff        <= run_in;
      rsp_status_ff <= rsp_status_in;
      rsp_proc_ff   <= rsp_proc_in;
      rsp_est_ff    <= rsp_est_in;
   end

endmodule

// File: rtl/hrrn_mul_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrrn_mul_unit
// shared unsigned multiplier with a registered product, used for the ratio
// cross products and the estimate average
// ----------------------------------------------------------------------------
module hrrn_mul_unit (
   input  logic                            clock,
   input  logic [hrrn_pkg::MUL_A_W-1:0]    op_a,
   input  logic [hrrn_pkg::MUL_B_W-1:0]    op_b,
   output logic [hrrn_pkg::PROD_W-1:0]     product
);

   logic [hrrn_pkg::PROD_W-1:0] product_ff;
   logic [hrrn_pkg::PROD_W-1:0] product_in;

   assign product_in = hrrn_pkg::PROD_W'(op_a) * hrrn_pkg::PROD_W'(op_b);
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule
